// ===== design/tsva_pkg.sv =====
package tsva_pkg;

  localparam int unsigned RtpHeaderBytes   = 12;
  localparam int unsigned TsPacketBytes    = 188;
  localparam int unsigned MaxTsPerDatagram = 7;
  localparam int unsigned PesHeadBytes     = 14;
  localparam int unsigned PtsPesOffset     = 9;
  localparam int unsigned MsDivisor        = 90;

  localparam int unsigned PosW    = 11;
  localparam int unsigned PidW    = 13;
  localparam int unsigned SumW    = 11;
  localparam int unsigned CcW     = 4;
  localparam int unsigned PtsRawW = 40;
  localparam int unsigned PtsHzW  = 33;
  localparam int unsigned MsW     = 27;
  localparam int unsigned ChainW  = 16;

  localparam logic [PidW-1:0] VideoPidReset = 13'h1011;

  typedef enum logic [1:0] {
    ActDiscard     = 2'd0,
    ActAppend      = 2'd1,
    ActCloseAppend = 2'd2,
    ActDrop        = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [SumW-1:0]   video_bytes;
    logic [CcW-1:0]    cc_first;
    logic [CcW-1:0]    cc_last;
    logic              start_found;
    logic              length_error;
  } res_info_t;

  typedef struct packed {
    res_info_t         info;
    logic [PtsHzW-1:0] closed_hz;
  } slice_res_t;

endpackage

// ===== design/ts_video_slice_assembler.sv =====
// channel | handshake               | payload
// cfg     | cfg_valid_i/cfg_ready_o | cfg_video_pid_i
// in      | in_valid_i/in_ready_o   | data_byte_i, last_byte_i
// out     | out_valid_o/out_ready_i | action_o, closed_pts_ms_o, video_bytes_o,
//         |                         | cc_first_o, cc_last_o, start_found_o, length_error_o
// one byte per cycle while no last byte waits; a byte is parsed the cycle after its transfer
// the result for a datagram is formed when its last byte leaves the parse register; three result
// stages behind the parse register do the divide by 90 as a halving and a reciprocal multiply
// the result stages are elastic; bytes keep flowing until a last byte finds all three full
// reset is asynchronous, active low; no clearing pass is needed
module ts_video_slice_assembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_video_pid_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [26:0] closed_pts_ms_o,
  output logic [10:0] video_bytes_o,
  output logic [3:0]  cc_first_o,
  output logic [3:0]  cc_last_o,
  output logic        start_found_o,
  output logic        length_error_o
);

  logic                 res_valid, res_ready;
  tsva_pkg::slice_res_t res;
  tsva_pkg::res_info_t  info;

  assign cfg_ready_o = 1'b1;

  tsva_parser u_parser (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_video_pid_i,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .last_byte_i,
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  tsva_div_pipe u_div_pipe (
    .clk_i,
    .rst_ni,
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o,
    .out_ready_i,
    .info_o      (info),
    .closed_ms_o (closed_pts_ms_o)
  );

  assign action_o       = info.action;
  assign video_bytes_o  = info.video_bytes;
  assign cc_first_o     = info.cc_first;
  assign cc_last_o      = info.cc_last;
  assign start_found_o  = info.start_found;
  assign length_error_o = info.length_error;

endmodule

// ===== design/tsva_parser.sv =====
module tsva_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tsva_pkg::PidW-1:0]     cfg_video_pid_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output tsva_pkg::slice_res_t          res_o
);

  localparam int unsigned BodyEnd =
    tsva_pkg::RtpHeaderBytes + tsva_pkg::MaxTsPerDatagram * tsva_pkg::TsPacketBytes;
  localparam logic [tsva_pkg::PosW-1:0] PosMax = {tsva_pkg::PosW{1'b1}};
  localparam logic [7:0] TsLastPos   = 8'(tsva_pkg::TsPacketBytes - 1);
  localparam logic [7:0] AdaptMax    = 8'(tsva_pkg::TsPacketBytes - 5);
  localparam logic [tsva_pkg::SumW-1:0] StartBytes =
    tsva_pkg::SumW'(tsva_pkg::TsPacketBytes - 4 - tsva_pkg::PesHeadBytes);
  localparam logic [tsva_pkg::SumW-1:0] PlainBytes =
    tsva_pkg::SumW'(tsva_pkg::TsPacketBytes - 4);
  localparam logic [9:0] PtsBase0    = 10'(4 + tsva_pkg::PtsPesOffset);

  logic [tsva_pkg::PidW-1:0]    video_pid_q;
  logic                         in_valid_q, in_last_q;
  logic [7:0]                   in_byte_q;
  logic                         fire;

  logic [tsva_pkg::PosW-1:0]    dpos_q, dpos_d;
  logic [7:0]                   ts_pos_q, ts_pos_d;
  logic [31:0]                  ts_header_q, ts_header_d;
  logic [7:0]                   adapt_len_q, adapt_len_d;
  logic [tsva_pkg::PtsRawW-1:0] pts_q, pts_d;
  logic                         start_seen_q, start_seen_d;
  logic [tsva_pkg::SumW-1:0]    byte_sum_q, byte_sum_d;
  logic [tsva_pkg::CcW-1:0]     first_cc_q, first_cc_d;
  logic [tsva_pkg::CcW-1:0]     recent_cc_q, recent_cc_d;
  logic                         video_seen_q, video_seen_d;
  logic                         capturing_q, capturing_d;

  logic                         waiting_q, waiting_d;
  logic [tsva_pkg::ChainW-1:0]  chain_len_q, chain_len_d;
  logic [tsva_pkg::CcW-1:0]     stored_cc_q, stored_cc_d;
  logic [tsva_pkg::PtsHzW-1:0]  slice_hz_q, slice_hz_d;

  logic                         in_body;
  logic [tsva_pkg::PidW-1:0]    pid;
  logic                         pusi, video;
  logic [1:0]                   afc;
  logic [tsva_pkg::CcW-1:0]     cc;
  logic [8:0]                   af_len;
  logic [9:0]                   pts_base, tpos;
  logic [2:0]                   pts_off;
  logic [tsva_pkg::PtsHzW-1:0]  hz;
  logic                         len_ok;
  tsva_pkg::action_e            action;
  logic [tsva_pkg::PtsHzW-1:0]  closed_hz;

  assign fire        = in_valid_q && (!in_last_q || res_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign res_valid_o = in_valid_q && in_last_q;

  // per-byte parse
  always_comb begin
    dpos_d       = (dpos_q == PosMax) ? dpos_q : dpos_q + 1'b1;
    ts_pos_d     = ts_pos_q;
    ts_header_d  = ts_header_q;
    adapt_len_d  = adapt_len_q;
    pts_d        = pts_q;
    start_seen_d = start_seen_q;
    byte_sum_d   = byte_sum_q;
    first_cc_d   = first_cc_q;
    recent_cc_d  = recent_cc_q;
    video_seen_d = video_seen_q;
    capturing_d  = capturing_q;
    pts_off      = 3'd0;

    in_body = (dpos_q >= tsva_pkg::PosW'(tsva_pkg::RtpHeaderBytes)) &&
              (dpos_q < tsva_pkg::PosW'(BodyEnd));

    if (in_body && ts_pos_q < 8'd4) begin
      ts_header_d = {ts_header_q[23:0], in_byte_q};
    end
    pid   = ts_header_d[20:8];
    pusi  = ts_header_d[22];
    afc   = ts_header_d[5:4];
    cc    = ts_header_d[3:0];
    video = (pid == video_pid_q);

    if (in_body && ts_pos_q == 8'd4) begin
      adapt_len_d = in_byte_q;
    end
    af_len   = afc[1] ? 9'(adapt_len_d) + 9'd1 : 9'd0;
    pts_base = PtsBase0 + 10'(af_len);
    tpos     = 10'(ts_pos_q);

    if (in_body) begin
      if (ts_pos_q == 8'd3 && video) begin
        if (!video_seen_q) begin
          first_cc_d = cc;
        end
        recent_cc_d  = cc;
        video_seen_d = 1'b1;
        if (pusi) begin
          byte_sum_d = byte_sum_q + StartBytes;
          if (!start_seen_q) begin
            start_seen_d = 1'b1;
            capturing_d  = 1'b1;
            pts_d        = '0;
          end
        end else if (afc == 2'b01) begin
          byte_sum_d = byte_sum_q + PlainBytes;
        end
      end
      if (ts_pos_q == 8'd4 && video && !pusi && afc == 2'b11 && in_byte_q <= AdaptMax) begin
        byte_sum_d = byte_sum_q + tsva_pkg::SumW'(AdaptMax - in_byte_q);
      end
      if (capturing_q && ts_pos_q >= 8'd4 && tpos >= pts_base && tpos < pts_base + 10'd5) begin
        pts_off = 3'(tpos - pts_base);
        case (pts_off)
          3'd0:    pts_d[39:32] = pts_d[39:32] | in_byte_q;
          3'd1:    pts_d[31:24] = pts_d[31:24] | in_byte_q;
          3'd2:    pts_d[23:16] = pts_d[23:16] | in_byte_q;
          3'd3:    pts_d[15:8]  = pts_d[15:8]  | in_byte_q;
          default: pts_d[7:0]   = pts_d[7:0]   | in_byte_q;
        endcase
      end
      if (ts_pos_q >= TsLastPos) begin
        ts_pos_d    = 8'd0;
        capturing_d = 1'b0;
      end else begin
        ts_pos_d = ts_pos_q + 8'd1;
      end
    end
  end

  // end of datagram: length check and chain decision
  always_comb begin
    hz = {pts_d[35:33], pts_d[31:17], pts_d[15:1]};

    len_ok = 1'b0;
    for (int k = 1; k <= int'(tsva_pkg::MaxTsPerDatagram); k++) begin
      if (dpos_d == tsva_pkg::PosW'(tsva_pkg::RtpHeaderBytes + k * tsva_pkg::TsPacketBytes)) begin
        len_ok = 1'b1;
      end
    end

    waiting_d   = waiting_q;
    chain_len_d = chain_len_q;
    stored_cc_d = stored_cc_q;
    slice_hz_d  = slice_hz_q;
    action      = tsva_pkg::ActAppend;
    closed_hz   = '0;

    if (waiting_q && !start_seen_d) begin
      action = tsva_pkg::ActDiscard;
    end else begin
      waiting_d = 1'b0;
      if (start_seen_d) begin
        if (chain_len_q != '0) begin
          closed_hz   = slice_hz_q;
          action      = tsva_pkg::ActCloseAppend;
          chain_len_d = '0;
        end
        slice_hz_d = hz;
      end
      if (chain_len_d == '0) begin
        if (video_seen_d) begin
          stored_cc_d = recent_cc_d;
        end
      end else if (!video_seen_d || (stored_cc_q + 1'b1) == first_cc_d) begin
        if (video_seen_d) begin
          stored_cc_d = recent_cc_d;
        end
      end else begin
        action      = tsva_pkg::ActDrop;
        waiting_d   = 1'b1;
        chain_len_d = '0;
      end
      if (action != tsva_pkg::ActDrop && chain_len_d != {tsva_pkg::ChainW{1'b1}}) begin
        chain_len_d = chain_len_d + 1'b1;
      end
    end

    if (len_ok) begin
      res_o.info.action       = action;
      res_o.info.video_bytes  = byte_sum_d;
      res_o.info.cc_first     = video_seen_d ? first_cc_d : '0;
      res_o.info.cc_last      = video_seen_d ? recent_cc_d : '0;
      res_o.info.start_found  = start_seen_d;
      res_o.info.length_error = 1'b0;
      res_o.closed_hz         = closed_hz;
    end else begin
      res_o.info.action       = tsva_pkg::ActDiscard;
      res_o.info.video_bytes  = '0;
      res_o.info.cc_first     = '0;
      res_o.info.cc_last      = '0;
      res_o.info.start_found  = 1'b0;
      res_o.info.length_error = 1'b1;
      res_o.closed_hz         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_pid_q <= tsva_pkg::VideoPidReset;
    end else if (cfg_valid_i) begin
      video_pid_q <= cfg_video_pid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpos_q       <= '0;
      ts_pos_q     <= '0;
      ts_header_q  <= '0;
      adapt_len_q  <= '0;
      pts_q        <= '0;
      start_seen_q <= 1'b0;
      byte_sum_q   <= '0;
      first_cc_q   <= '0;
      recent_cc_q  <= '0;
      video_seen_q <= 1'b0;
      capturing_q  <= 1'b0;
    end else if (fire) begin
      if (in_last_q) begin
        dpos_q       <= '0;
        ts_pos_q     <= '0;
        ts_header_q  <= '0;
        adapt_len_q  <= '0;
        pts_q        <= '0;
        start_seen_q <= 1'b0;
        byte_sum_q   <= '0;
        first_cc_q   <= '0;
        recent_cc_q  <= '0;
        video_seen_q <= 1'b0;
        capturing_q  <= 1'b0;
      end else begin
        dpos_q       <= dpos_d;
        ts_pos_q     <= ts_pos_d;
        ts_header_q  <= ts_header_d;
        adapt_len_q  <= adapt_len_d;
        pts_q        <= pts_d;
        start_seen_q <= start_seen_d;
        byte_sum_q   <= byte_sum_d;
        first_cc_q   <= first_cc_d;
        recent_cc_q  <= recent_cc_d;
        video_seen_q <= video_seen_d;
        capturing_q  <= capturing_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b1;
      chain_len_q <= '0;
      stored_cc_q <= '0;
      slice_hz_q  <= '0;
    end else if (fire && in_last_q && len_ok) begin
      waiting_q   <= waiting_d;
      chain_len_q <= chain_len_d;
      stored_cc_q <= stored_cc_d;
      slice_hz_q  <= slice_hz_d;
    end
  end

endmodule

// ===== design/tsva_div_pipe.sv =====
module tsva_div_pipe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      res_valid_i,
  output logic                      res_ready_o,
  input  tsva_pkg::slice_res_t      res_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tsva_pkg::res_info_t       info_o,
  output logic [tsva_pkg::MsW-1:0]  closed_ms_o
);

  // divide by 90: halve, then multiply by ceil(2^38 / 45) and drop 38 bits
  localparam logic [30:0] RecipLo    = 31'd1813430637;
  localparam int unsigned RecipShift = 38;

  logic                     head_valid_q, prod_valid_q, ms_valid_q;
  logic                     head_ready, prod_ready, ms_ready;
  tsva_pkg::res_info_t      head_info_q, prod_info_q, ms_info_q;
  logic [31:0]              head_half_q, prod_half_q;
  logic [46:0]              prod_lo_q, prod_hi_q;
  logic [64:0]              sum;
  logic [tsva_pkg::MsW-1:0] ms_q;

  assign ms_ready   = !ms_valid_q || out_ready_i;
  assign prod_ready = !prod_valid_q || ms_ready;
  assign head_ready = !head_valid_q || prod_ready;

  assign sum = 65'(prod_lo_q) + {2'b0, prod_hi_q, 16'b0} + {1'b0, prod_half_q, 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      prod_valid_q <= 1'b0;
      ms_valid_q   <= 1'b0;
    end else begin
      if (head_ready) begin
        head_valid_q <= res_valid_i;
      end
      if (prod_ready) begin
        prod_valid_q <= head_valid_q;
      end
      if (ms_ready) begin
        ms_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_ready && res_valid_i) begin
      head_info_q <= res_i.info;
      head_half_q <= res_i.closed_hz[tsva_pkg::PtsHzW-1:1];
    end
    if (prod_ready && head_valid_q) begin
      prod_info_q <= head_info_q;
      prod_half_q <= head_half_q;
      prod_lo_q   <= 47'(head_half_q[15:0]) * 47'(RecipLo);
      prod_hi_q   <= 47'(head_half_q[31:16]) * 47'(RecipLo);
    end
    if (ms_ready && prod_valid_q) begin
      ms_info_q <= prod_info_q;
      ms_q      <= sum[RecipShift +: tsva_pkg::MsW];
    end
  end

  assign res_ready_o = head_ready;
  assign out_valid_o = ms_valid_q;
  assign info_o      = ms_info_q;
  assign closed_ms_o = ms_q;

endmodule

// ===== design/tsva_checker.sv =====
module tsva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  action_o,
  input logic [26:0] closed_pts_ms_o,
  input logic [10:0] video_bytes_o,
  input logic [3:0]  cc_first_o,
  input logic [3:0]  cc_last_o,
  input logic        start_found_o,
  input logic        length_error_o
);

  // a bad length result carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> action_o == tsva_pkg::ActDiscard &&
      video_bytes_o == '0 && cc_first_o == '0 && cc_last_o == '0 && !start_found_o &&
      closed_pts_ms_o == '0)
    else $error("length error result not cleared");

  // a closed slice time only comes with a close
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && closed_pts_ms_o != '0 |-> action_o == tsva_pkg::ActCloseAppend)
    else $error("closed time without close");

  // a close needs a start in this datagram
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == tsva_pkg::ActCloseAppend |-> start_found_o)
    else $error("close without start");

  // seven packets at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> video_bytes_o <= 11'd1316)
    else $error("video byte count out of range");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) &&
      $stable(closed_pts_ms_o) && $stable(video_bytes_o))
    else $error("stalled result changed");

endmodule

bind ts_video_slice_assembler tsva_checker u_tsva_checker (.*);
